[design/sepe_pkg.sv]
// Package for the socket event payload extractor.
// Holds the shared constants, types and the header/digit helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sepe_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int HDR_LEN     = 18;
  localparam int HDR_CW      = 5;
  localparam int DEC_BASE    = 10;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [HDR_LEN*8-1:0] EVENT_TEXT = "+EVENT:SocketDown,";

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // register index, taken from paddr[2]
  localparam logic REG_TARGET_ID = 1'b0;
  localparam logic REG_SOCK_OPEN = 1'b1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [HDR_CW-1:0]      hdr_cnt_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } sepe_res_t;

  typedef struct packed {
    logic idle;
  } sepe_stat_t;

  function automatic logic [7:0] hdr_char(input hdr_cnt_t idx);
    logic [7:0] ch;
    ch = '0;
    for (int i = 0; i < HDR_LEN; i++) begin
      if (idx == hdr_cnt_t'(i)) begin
        ch = EVENT_TEXT[8*(HDR_LEN-1-i) +: 8];
      end
    end
    return ch;
  endfunction

  function automatic count_t fold_digit(input count_t acc, input logic [7:0] b);
    count_t prod;
    prod = acc * count_t'(DEC_BASE);
    return prod + count_t'(b) - count_t'(CHAR_ZERO);
  endfunction

endpackage

`default_nettype wire

[design/socket_event_payload_extractor.sv]
// Socket event payload extractor, top level.
// Path: an input byte is captured in the stage register, then parsed and loaded
// into the result register when the output slot is free. Throughput: one byte
// per cycle while the output is not stalled; set by the single parse stage.
// Reset: synchronous active-low; parser idle, config registers cleared.
`timescale 1ns / 1ps
`default_nettype none

module socket_event_payload_extractor (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [7:0]                    out_payload_byte,
  output logic                          out_payload_last,
  input  wire                           cfg_psel,
  input  wire                           cfg_penable,
  input  wire                           cfg_pwrite,
  input  wire  [sepe_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire  [sepe_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [sepe_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import sepe_pkg::*;

  count_t     target_id_r;
  logic       sock_open_r;
  logic       cfg_wr;
  logic       stage_valid_r;
  logic [7:0] stage_byte_r;
  logic       advance;
  logic       slot_free;
  logic       in_xfer;
  sepe_res_t  res;
  sepe_stat_t stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_id_r <= '0;
      sock_open_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_TARGET_ID: target_id_r <= cfg_pwdata[COUNT_WIDTH-1:0];
        REG_SOCK_OPEN: sock_open_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_TARGET_ID: cfg_prdata = DATA_W'(target_id_r);
      REG_SOCK_OPEN: cfg_prdata = DATA_W'(sock_open_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign advance  = stage_valid_r && slot_free;
  assign in_ready = !stage_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_xfer) begin
      stage_valid_r <= 1'b1;
    end else if (advance) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_byte_r <= in_rx_byte;
    end
  end

  sepe_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .rx_byte   (stage_byte_r),
    .target_id (target_id_r),
    .sock_open (sock_open_r),
    .res       (res),
    .stat      (stat)
  );

  sepe_out_buf u_out_buf (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_payload_byte (out_payload_byte),
    .out_payload_last (out_payload_last),
    .slot_free        (slot_free)
  );

`ifndef SYNTHESIS
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && !slot_free |=> stage_valid_r && $stable(stage_byte_r))
    else $error("staged byte lost while result slot blocked");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.last |=> stat.idle)
    else $error("parser not idle after last payload byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> stat.idle && !out_valid)
    else $error("parser or result register not cleared by reset");
`endif

endmodule

`default_nettype wire

[design/sepe_parse.sv]
// Event parser: phase sequencer, header compare, id/length accumulators.
// Consumes one staged byte per advance. Depends on sepe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sepe_parse (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    advance,
  input  wire  [7:0]             rx_byte,
  input  wire  sepe_pkg::count_t target_id,
  input  wire                    sock_open,
  output sepe_pkg::sepe_res_t    res,
  output sepe_pkg::sepe_stat_t   stat
);
  import sepe_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR  = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_PAY  = 3'd4
  } phase_t;

  phase_t   phase_r, phase_nxt;
  hdr_cnt_t hdr_cnt_r, hdr_cnt_nxt;
  logic     mismatch_r, mismatch_nxt;
  count_t   id_acc_r, id_acc_nxt;
  count_t   len_acc_r, len_acc_nxt;
  count_t   pay_cnt_r, pay_cnt_nxt;

  hdr_cnt_t hdr_inc;
  logic     mis_now;
  count_t   pay_inc;
  logic     pay_last;
  logic     fwd;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    mismatch_nxt = mismatch_r;
    id_acc_nxt   = id_acc_r;
    len_acc_nxt  = len_acc_r;
    pay_cnt_nxt  = pay_cnt_r;
    hdr_inc      = hdr_cnt_r + hdr_cnt_t'(1);
    mis_now      = mismatch_r ||
                   ((hdr_cnt_r < hdr_cnt_t'(HDR_LEN)) && (rx_byte != hdr_char(hdr_cnt_r)));
    pay_inc      = pay_cnt_r + count_t'(1);
    pay_last     = (pay_inc >= len_acc_r);
    fwd          = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
        if (rx_byte == CHAR_PLUS) begin
          phase_nxt    = PH_HDR;
          hdr_cnt_nxt  = hdr_cnt_t'(1);
          mismatch_nxt = 1'b0;
        end
      end
      PH_HDR: begin
        mismatch_nxt = mis_now;
        hdr_cnt_nxt  = hdr_inc;
        if (hdr_inc >= hdr_cnt_t'(HDR_LEN)) begin
          phase_nxt    = mis_now ? PH_IDLE : PH_ID;
          hdr_cnt_nxt  = '0;
          mismatch_nxt = 1'b0;
          id_acc_nxt   = '0;
          len_acc_nxt  = '0;
          pay_cnt_nxt  = '0;
        end
      end
      PH_ID: begin
        if (rx_byte == CHAR_COMMA) begin
          phase_nxt = PH_LEN;
        end else begin
          id_acc_nxt = fold_digit(id_acc_r, rx_byte);
        end
      end
      PH_LEN: begin
        if (rx_byte == CHAR_COMMA) begin
          phase_nxt   = PH_PAY;
          pay_cnt_nxt = '0;
        end else begin
          len_acc_nxt = fold_digit(len_acc_r, rx_byte);
        end
      end
      PH_PAY: begin
        fwd = sock_open && (id_acc_r == target_id);
        if (pay_last) begin
          phase_nxt    = PH_IDLE;
          hdr_cnt_nxt  = '0;
          mismatch_nxt = 1'b0;
          id_acc_nxt   = '0;
          len_acc_nxt  = '0;
          pay_cnt_nxt  = '0;
        end else begin
          pay_cnt_nxt = pay_inc;
        end
      end
      default: begin
        phase_nxt    = PH_IDLE;
        hdr_cnt_nxt  = '0;
        mismatch_nxt = 1'b0;
        id_acc_nxt   = '0;
        len_acc_nxt  = '0;
        pay_cnt_nxt  = '0;
      end
    endcase
  end

  assign res.valid = advance && fwd;
  assign res.data  = rx_byte;
  assign res.last  = pay_last;
  assign stat.idle = (phase_r == PH_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      hdr_cnt_r  <= '0;
      mismatch_r <= 1'b0;
      id_acc_r   <= '0;
      len_acc_r  <= '0;
      pay_cnt_r  <= '0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      mismatch_r <= mismatch_nxt;
      id_acc_r   <= id_acc_nxt;
      len_acc_r  <= len_acc_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[design/sepe_out_buf.sv]
// Result register for forwarded payload bytes.
// Loads a result when the slot is free; depends on sepe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sepe_out_buf (
  input  wire                 clk,
  input  wire                 rst_n,
  input  sepe_pkg::sepe_res_t res,
  input  wire                 out_ready,
  output logic                out_valid,
  output logic [7:0]          out_payload_byte,
  output logic                out_payload_last,
  output logic                slot_free
);
  import sepe_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;

  assign slot_free        = !valid_r || out_ready;
  assign out_valid        = valid_r;
  assign out_payload_byte = data_r;
  assign out_payload_last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      data_r <= res.data;
      last_r <= res.last;
    end
  end

endmodule

`default_nettype wire
